// File: hdl/fssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssc_pkg
// shared types, widths and codes of the floppy seek / step controller
// ----------------------------------------------------------------------------
package fssc_pkg;

    localparam int CYL_W = 8;
    localparam int TMR_W = 16;
    localparam int CFG_W = 16;
    localparam int TRY_W = 8;

    localparam logic [TMR_W-1:0] TMR_MAX = '1;
    localparam logic [TRY_W-1:0] TRY_MAX = '1;

    localparam logic [15:0] WAIT_RST   = 16'd125;
    localparam logic [15:0] PULSE_RST  = 16'd13;
    localparam logic [15:0] SETTLE_RST = 16'd350;
    localparam logic [7:0]  TRIES_RST  = 8'd85;

    typedef logic [CYL_W-1:0] cyl_t;
    typedef logic [TMR_W-1:0] tmr_t;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_SEEK   = 2'd1,
        FN_RECAL  = 2'd2,
        FN_RETURN = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MD_NONE   = 2'd0,
        MD_SEEK   = 2'd1,
        MD_RECAL  = 2'd2,
        MD_RETURN = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DIRWAIT  = 5'b00010,
        PH_PULSE    = 5'b00100,
        PH_POSTWAIT = 5'b01000,
        PH_SETTLE   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        REG_WAIT   = 2'd0,
        REG_PULSE  = 2'd1,
        REG_SETTLE = 2'd2,
        REG_TRIES  = 2'd3
    } cfg_idx_t;

    // timer load, saturating at the timer maximum
    function automatic tmr_t tmr_load(input logic [CFG_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > 33'(TMR_MAX))
        begin
            return TMR_MAX;
        end
        return TMR_W'(w);
    endfunction

endpackage

// File: hdl/floppy_seek_step_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_seek_step_controller_unit
// result: registered, shown in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while a held result is not stalled;
//   the state update and the result register are loaded at the same edge,
//   the result register frees itself whenever the result is taken
// reset: asynchronous, active low; idle, cylinder 0, outward, default timing
// ----------------------------------------------------------------------------
module floppy_seek_step_controller_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [fssc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [7:0]                    target_cylinder,
    input  logic                          track_zero,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          step_active,
    output logic                          dir_inward,
    output logic                          busy_res,
    output logic                          done_res,
    output logic                          error,
    output logic [7:0]                    cylinder
);

    // configuration
    logic [15:0] wait_ticks_reg;
    logic [15:0] pulse_ticks_reg;
    logic [15:0] settle_ticks_reg;
    logic [7:0]  max_tries_reg;

    // controller state
    fssc_pkg::phase_t             phase_reg, phase_next;
    fssc_pkg::mode_t              mode_reg, mode_next;
    fssc_pkg::cyl_t               head_reg, head_next;
    fssc_pkg::cyl_t               goal_reg, goal_next;
    fssc_pkg::tmr_t               timer_reg, timer_next;
    logic [fssc_pkg::TRY_W-1:0]   try_reg, try_next;
    logic                         err_reg, err_next;
    logic                         dir_reg, dir_next;
    logic                         done_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        step_reg, dir_out_reg, busy_reg, done_reg, err_out_reg;
    logic [7:0]  cyl_out_reg;

    logic in_acc;

    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;

    always_comb
    begin
        fssc_pkg::func_t fn;
        fssc_pkg::cyl_t  tgt;
        fssc_pkg::cyl_t  goal;
        fssc_pkg::tmr_t  tdec;
        logic            start;
        logic            step_next;

        fn    = fssc_pkg::func_t'(func);
        tgt   = fssc_pkg::CYL_W'(target_cylinder);
        tdec  = '0;
        start = 1'b0;
        step_next = 1'b0;

        phase_next = phase_reg;
        mode_next  = mode_reg;
        head_next  = head_reg;
        goal_next  = goal_reg;
        timer_next = timer_reg;
        try_next   = try_reg;
        err_next   = err_reg;
        dir_next   = dir_reg;
        done_next  = 1'b0;

        if (in_acc)
        begin
            if (fn == fssc_pkg::FN_TICK)
            begin
                if (phase_reg != fssc_pkg::PH_IDLE)
                begin
                    tdec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
                    timer_next = tdec;
                    if (tdec == '0)
                    begin
                        case (phase_reg)
                            fssc_pkg::PH_DIRWAIT:
                            begin
                                if (mode_reg == fssc_pkg::MD_RETURN && track_zero)
                                begin
                                    err_next = 1'b1;
                                end
                                phase_next = fssc_pkg::PH_PULSE;
                                timer_next = fssc_pkg::tmr_load(pulse_ticks_reg);
                            end
                            fssc_pkg::PH_PULSE:
                            begin
                                if (mode_reg == fssc_pkg::MD_SEEK
                                    || mode_reg == fssc_pkg::MD_RETURN)
                                begin
                                    step_next = 1'b1;
                                end
                                else
                                begin
                                    if (try_reg != fssc_pkg::TRY_MAX)
                                    begin
                                        try_next = try_reg + 1'b1;
                                    end
                                    phase_next = fssc_pkg::PH_POSTWAIT;
                                    timer_next = fssc_pkg::tmr_load(wait_ticks_reg);
                                end
                            end
                            fssc_pkg::PH_POSTWAIT:
                            begin
                                if (try_reg > max_tries_reg
                                    || try_reg == fssc_pkg::TRY_MAX)
                                begin
                                    err_next   = 1'b1;
                                    phase_next = fssc_pkg::PH_IDLE;
                                    mode_next  = fssc_pkg::MD_NONE;
                                    timer_next = '0;
                                    done_next  = 1'b1;
                                end
                                else if (track_zero)
                                begin
                                    phase_next = fssc_pkg::PH_SETTLE;
                                    timer_next = fssc_pkg::tmr_load(settle_ticks_reg);
                                end
                                else
                                begin
                                    phase_next = fssc_pkg::PH_PULSE;
                                    timer_next = fssc_pkg::tmr_load(pulse_ticks_reg);
                                end
                            end
                            default:
                            begin
                                if (mode_reg == fssc_pkg::MD_RECAL)
                                begin
                                    head_next = '0;
                                end
                                else if (mode_reg == fssc_pkg::MD_RETURN && !track_zero)
                                begin
                                    err_next = 1'b1;
                                end
                                phase_next = fssc_pkg::PH_IDLE;
                                mode_next  = fssc_pkg::MD_NONE;
                                timer_next = '0;
                                done_next  = 1'b1;
                            end
                        endcase
                    end
                end
            end
            else if (phase_reg == fssc_pkg::PH_IDLE)
            begin
                start     = 1'b1;
                mode_next = fssc_pkg::mode_t'(fn);
                err_next  = 1'b0;
                try_next  = '0;
                case (fn)
                    fssc_pkg::FN_SEEK:
                    begin
                        goal_next = tgt;
                        step_next = 1'b1;
                    end
                    fssc_pkg::FN_RECAL:
                    begin
                        dir_next = 1'b0;
                        if (track_zero)
                        begin
                            phase_next = fssc_pkg::PH_SETTLE;
                            timer_next = fssc_pkg::tmr_load(settle_ticks_reg);
                        end
                        else
                        begin
                            phase_next = fssc_pkg::PH_PULSE;
                            timer_next = fssc_pkg::tmr_load(pulse_ticks_reg);
                        end
                    end
                    default:
                    begin
                        step_next = 1'b1;
                    end
                endcase
            end
        end

        // next cylinder step of a seek or a verified return
        goal = start ? tgt : goal_reg;
        if (step_next)
        begin
            if (mode_next == fssc_pkg::MD_SEEK)
            begin
                if (head_reg == goal)
                begin
                    phase_next = fssc_pkg::PH_SETTLE;
                    timer_next = fssc_pkg::tmr_load(settle_ticks_reg);
                end
                else
                begin
                    dir_next   = (goal > head_reg);
                    head_next  = (goal > head_reg) ? head_reg + 1'b1 : head_reg - 1'b1;
                    phase_next = fssc_pkg::PH_DIRWAIT;
                    timer_next = fssc_pkg::tmr_load(wait_ticks_reg);
                end
            end
            else
            begin
                dir_next = 1'b0;
                if (head_reg == '0)
                begin
                    phase_next = fssc_pkg::PH_SETTLE;
                    timer_next = fssc_pkg::tmr_load(settle_ticks_reg);
                end
                else
                begin
                    head_next  = head_reg - 1'b1;
                    phase_next = fssc_pkg::PH_DIRWAIT;
                    timer_next = fssc_pkg::tmr_load(wait_ticks_reg);
                end
            end
        end
    end

    assign out_valid_next = in_acc | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg   <= fssc_pkg::WAIT_RST;
            pulse_ticks_reg  <= fssc_pkg::PULSE_RST;
            settle_ticks_reg <= fssc_pkg::SETTLE_RST;
            max_tries_reg    <= fssc_pkg::TRIES_RST;
        end
        else if (cfg_we)
        begin
            case (fssc_pkg::cfg_idx_t'(cfg_index))
                fssc_pkg::REG_WAIT:   wait_ticks_reg   <= 16'(cfg_data);
                fssc_pkg::REG_PULSE:  pulse_ticks_reg  <= 16'(cfg_data);
                fssc_pkg::REG_SETTLE: settle_ticks_reg <= 16'(cfg_data);
                fssc_pkg::REG_TRIES:  max_tries_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fssc_pkg::PH_IDLE;
            mode_reg      <= fssc_pkg::MD_NONE;
            head_reg      <= '0;
            goal_reg      <= '0;
            timer_reg     <= '0;
            try_reg       <= '0;
            err_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            head_reg      <= head_next;
            goal_reg      <= goal_next;
            timer_reg     <= timer_next;
            try_reg       <= try_next;
            err_reg       <= err_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            step_reg    <= (phase_next == fssc_pkg::PH_PULSE);
            dir_out_reg <= dir_next;
            busy_reg    <= (phase_next != fssc_pkg::PH_IDLE);
            done_reg    <= done_next;
            err_out_reg <= err_next;
            cyl_out_reg <= 8'(head_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign step_active = step_reg;
    assign dir_inward  = dir_out_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign error       = err_out_reg;
    assign cylinder    = cyl_out_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_active |-> busy_res)
        else $error("step pulse while idle");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction gave no result");

    a_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fssc_pkg::PH_IDLE) == (mode_reg == fssc_pkg::MD_NONE))
        else $error("mode and phase disagree");

endmodule
